/* rtl/rpfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfb_pkg
// Shared types and codes for the rotated packed-pixel frame buffer.
// ----------------------------------------------------------------------------
package rpfb_pkg;

    localparam int DEF_PANEL_WIDTH  = 168;
    localparam int DEF_PANEL_HEIGHT = 384;

    // Byte index as computed by the front end, before range check.
    // Covers the largest panel: 511 row pairs * 128 bytes + 127.
    localparam int IDX_W = 17;

    // Command field codes
    localparam logic [1:0] CMD_PLOT = 2'd0;
    localparam logic [1:0] CMD_FILL = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Task codes passed from front end to back end
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_PLOT = 2'd1;
    localparam logic [1:0] OP_FILL = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic             clip;
        logic             on;
        logic [2:0]       bitpos;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } t_task;

endpackage
`default_nettype wire

/* rtl/rpfb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfb_front
// Takes command beats, applies rotation and clipping, and hands a decoded
// task to the queue through one register stage.
// ----------------------------------------------------------------------------
module rpfb_front
    import rpfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_pixel_x,
    input  wire logic [9:0]  i_pixel_y,
    input  wire logic        i_pixel_on,
    input  wire logic [7:0]  i_fill_byte,
    input  wire logic [12:0] i_read_index,
    output logic             o_task_valid,
    input  wire logic        i_task_ready,
    output t_task            o_task
);

    localparam int ROW_BYTES   = PANEL_WIDTH / 4;
    localparam int STORE_DEPTH = ROW_BYTES * (PANEL_HEIGHT / 2);

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic signed [11:0] W_S  = 12'(PANEL_WIDTH);
    localparam logic signed [11:0] H_S  = 12'(PANEL_HEIGHT);
    localparam logic signed [11:0] WM_S = 12'(PANEL_WIDTH - 1);
    localparam logic signed [11:0] HM_S = 12'(PANEL_HEIGHT - 1);

    logic [1:0]        r_rotation;
    logic              r_valid;
    t_task             r_task;
    t_task             n_task;
    logic              accept;
    logic signed [11:0] sx, sy, px, py;
    logic              off_panel;
    logic [IDX_W-1:0]  pidx;

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = r_valid && !i_task_ready;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_task_valid = r_valid;
    assign o_task       = r_task;

    always_comb begin
        sx = $signed({2'b00, i_pixel_x});
        sy = $signed({2'b00, i_pixel_y});
        case (r_rotation)
            ROT_0: begin
                px = sx;
                py = sy;
            end
            ROT_90: begin
                px = WM_S - sy;
                py = sx;
            end
            ROT_180: begin
                px = WM_S - sx;
                py = HM_S - sy;
            end
            ROT_270: begin
                px = sy;
                py = HM_S - sx;
            end
            default: begin
                px = sx;
                py = sy;
            end
        endcase
        off_panel = px[11] || py[11] || (px >= W_S) || (py >= H_S);
        // row pair times bytes per row, plus column quad
        pidx = IDX_W'(py[9:1]) * IDX_W'(ROW_BYTES) + IDX_W'(px[8:2]);

        n_task        = '0;
        n_task.on     = i_pixel_on;
        n_task.data   = i_fill_byte;
        n_task.bitpos = 3'd7 - {px[1:0], py[0]};
        case (i_command)
            CMD_PLOT: begin
                if (off_panel || (pidx >= IDX_W'(STORE_DEPTH))) begin
                    n_task.op   = OP_NONE;
                    n_task.clip = 1'b1;
                end else begin
                    n_task.op  = OP_PLOT;
                    n_task.idx = pidx;
                end
            end
            CMD_FILL: begin
                n_task.op = OP_FILL;
            end
            CMD_READ: begin
                if (IDX_W'(i_read_index) < IDX_W'(STORE_DEPTH)) begin
                    n_task.op  = OP_READ;
                    n_task.idx = IDX_W'(i_read_index);
                end else begin
                    n_task.op = OP_NONE;
                end
            end
            default: begin
                n_task.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= ROT_0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rotation <= i_cfg_data;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_task_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_task <= n_task;
        end
    end

endmodule
`default_nettype wire

/* rtl/rpfb_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfb_fifo
// Two-entry task queue between front end and back end.
// ----------------------------------------------------------------------------
module rpfb_fifo
    import rpfb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_task i_push_task,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_task      o_pop_task
);

    t_task      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_task   = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_task;
        end
    end

endmodule
`default_nettype wire

/* rtl/rpfb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfb_back
// Frame store with read-modify-write plotting, fill sweep, byte read-out
// and the result register.
// ----------------------------------------------------------------------------
module rpfb_back
    import rpfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_task_valid,
    output logic            o_task_ready,
    input  wire t_task      i_task,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_byte,
    output logic            o_clipped
);

    localparam int STORE_DEPTH = (PANEL_WIDTH / 4) * (PANEL_HEIGHT / 2);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [7:0]    r_store [STORE_DEPTH];
    logic [7:0]    r_rdata;
    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_task         r_task;
    logic [AW-1:0] r_fill_cnt;
    logic          r_out_valid;
    logic [7:0]    r_read_byte;
    logic          r_clipped;

    logic          can_out;
    logic          exec_done;
    logic          fill_done;
    logic          pop;
    logic          head_mem;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    bit_mask;
    logic          out_load;
    logic [7:0]    out_byte;
    logic          out_clip;

    assign o_out_valid  = r_out_valid;
    assign o_read_byte  = r_read_byte;
    assign o_clipped    = r_clipped;
    assign o_task_ready = pop;

    always_comb begin
        can_out   = !r_out_valid || !i_out_stall;
        exec_done = (r_state == ST_EXEC) && can_out;
        fill_done = (r_state == ST_FILL) && (r_fill_cnt == LAST_ADDR) && can_out;
        head_mem  = (i_task.op == OP_PLOT) || (i_task.op == OP_READ);

        // a no-op result goes straight to the output, so it needs the slot
        pop = 1'b0;
        if (i_task_valid) begin
            if (r_state == ST_IDLE) begin
                pop = (i_task.op != OP_NONE) || can_out;
            end else if (exec_done) begin
                pop = (i_task.op != OP_NONE);
            end
        end

        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_EXEC: begin
                if (r_state == ST_EXEC && exec_done) begin
                    n_state = ST_IDLE;
                end
                if (pop) begin
                    if (head_mem) begin
                        n_state = ST_EXEC;
                    end else if (i_task.op == OP_FILL) begin
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FILL: begin
                if (fill_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        bit_mask  = 8'd1 << r_task.bitpos;
        mem_raddr = i_task.idx[AW-1:0];
        if (r_state == ST_FILL) begin
            mem_we    = 1'b1;
            mem_waddr = r_fill_cnt;
            mem_wdata = r_task.data;
        end else begin
            mem_we    = exec_done && (r_task.op == OP_PLOT);
            mem_waddr = r_task.idx[AW-1:0];
            mem_wdata = r_task.on ? (r_rdata | bit_mask) : (r_rdata & ~bit_mask);
        end

        out_load = exec_done || fill_done || (pop && i_task.op == OP_NONE);
        out_byte = 8'd0;
        out_clip = 1'b0;
        if (exec_done) begin
            if (r_task.op == OP_READ) begin
                out_byte = r_rdata;
            end
        end else if (!fill_done) begin
            out_clip = i_task.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
    end

    // a plot write at the same edge as the next read is forwarded
    always_ff @(posedge i_clk) begin
        if (pop && head_mem) begin
            if (mem_we && (mem_waddr == mem_raddr)) begin
                r_rdata <= mem_wdata;
            end else begin
                r_rdata <= r_store[mem_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_fill_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                r_fill_cnt <= '0;
            end else if (r_state == ST_FILL && r_fill_cnt != LAST_ADDR) begin
                r_fill_cnt <= r_fill_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_task <= i_task;
        end
        if (out_load) begin
            r_read_byte <= out_byte;
            r_clipped   <= out_clip;
        end
    end

endmodule
`default_nettype wire

/* rtl/rotated_packed_pixel_framebuffer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_packed_pixel_framebuffer_core
// Packed monochrome frame buffer: rotated pixel plot, fill and byte read-out.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats enter on i_in_valid / o_in_stall; each produces exactly one
//   result beat on o_out_valid / i_out_stall (read byte and clip flag).
//   Rotation is written on the cfg channel (always ready); the user must
//   write it only while idle, as the block itself does not enforce this.
//   Plots and reads sustain one beat per cycle while the output is not
//   stalled: the back end overlaps one store read with the write of the
//   previous plot. A fill sweeps the store one byte per cycle and holds the
//   back end for all (PANEL_WIDTH/4)*(PANEL_HEIGHT/2) bytes, 8064 by default.
//   A front register stage and a two-entry queue let commands keep arriving
//   while the back end works or the output is stalled.
//   Reset clears rotation and the pipeline; store contents are undefined
//   until plotted or filled. When the receiver stalls, the result register
//   holds and the pipeline backs up to o_in_stall.
// ----------------------------------------------------------------------------
module rotated_packed_pixel_framebuffer_core
    import rpfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_pixel_x,
    input  wire logic [9:0]  i_pixel_y,
    input  wire logic        i_pixel_on,
    input  wire logic [7:0]  i_fill_byte,
    input  wire logic [12:0] i_read_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_byte,
    output logic             o_clipped
);

    logic  fe_valid;
    logic  fe_ready;
    t_task fe_task;
    logic  be_valid;
    logic  be_ready;
    t_task be_task;

    rpfb_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_pixel_on   (i_pixel_on),
        .i_fill_byte  (i_fill_byte),
        .i_read_index (i_read_index),
        .o_task_valid (fe_valid),
        .i_task_ready (fe_ready),
        .o_task       (fe_task)
    );

    rpfb_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_push_task  (fe_task),
        .o_pop_valid  (be_valid),
        .i_pop_ready  (be_ready),
        .o_pop_task   (be_task)
    );

    rpfb_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (be_valid),
        .o_task_ready (be_ready),
        .i_task       (be_task),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_byte  (o_read_byte),
        .o_clipped    (o_clipped)
    );

endmodule
`default_nettype wire
